FILE: hdl/ctok_pkg.sv
// Shared types and constants for the C subset tokenizer.
package ctok_pkg;

    // Token kind codes as seen on the result channel
    typedef enum logic [3:0] {
        KIND_LBRACE  = 4'd0,
        KIND_RBRACE  = 4'd1,
        KIND_LPAREN  = 4'd2,
        KIND_RPAREN  = 4'd3,
        KIND_SEMI    = 4'd4,
        KIND_RETURN  = 4'd5,
        KIND_IDENT   = 4'd6,
        KIND_INT     = 4'd7,
        KIND_LITERAL = 4'd8,
        KIND_NEG     = 4'd9,
        KIND_COMPL   = 4'd10,
        KIND_BANG    = 4'd11,
        KIND_UNKNOWN = 4'd12
    } kind_t;

    // Scanner mode, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_NUM  = 3'b010,
        MODE_WORD = 3'b100
    } mode_t;

    // One result token
    typedef struct packed {
        kind_t        token_kind;
        logic [31:0]  int_value;
        logic         value_overflow;
        logic [63:0]  ident_text;
        logic [7:0]   ident_length;
        logic         ident_too_long;
        logic         last_of_run;
    } token_t;

    // Up to two tokens written into the queue per accepted request
    typedef struct packed {
        logic   v0;
        logic   v1;
        token_t t0;
        token_t t1;
    } push_t;

    // Character codes
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_BANG   = 8'h21;

    // Keywords, packed first character in lowest byte
    localparam logic [63:0] KW_INT        = 64'h0000_0000_0074_6E69;
    localparam logic [63:0] KW_RETURN     = 64'h0000_6E72_7574_6572;
    localparam logic [7:0]  KW_INT_LEN    = 8'd3;
    localparam logic [7:0]  KW_RETURN_LEN = 8'd6;

    // Token queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

endpackage

FILE: hdl/ctok_front.sv
// Front end: classifies characters, tracks the pending literal or word, builds tokens.
module ctok_front #(
    parameter int MAX_ID_CHARS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          s_char_code,
    input  logic                s_end_of_input,
    output ctok_pkg::push_t     push
);

    ctok_pkg::mode_t mode_reg, mode_next;
    logic [31:0]     acc_reg, acc_next;
    logic            ovf_reg, ovf_next;
    logic [63:0]     buf_reg, buf_next;
    logic [7:0]      len_reg, len_next;

    logic            is_digit, is_letter, is_space, pend;
    logic [7:0]      digit_diff;
    logic [3:0]      digit;
    logic [35:0]     mac;
    logic [63:0]     buf_ins;
    logic [7:0]      len_inc;
    logic            take_num, take_word, emit_flush, emit_char;
    ctok_pkg::token_t flush_tok, char_tok;

    // Classify the incoming byte
    always_comb begin
        is_digit  = (s_char_code >= ctok_pkg::CH_ZERO) && (s_char_code <= ctok_pkg::CH_NINE);
        is_letter = ((s_char_code >= ctok_pkg::CH_UP_A) && (s_char_code <= ctok_pkg::CH_UP_Z))
                 || ((s_char_code >= ctok_pkg::CH_LO_A) && (s_char_code <= ctok_pkg::CH_LO_Z));
        is_space  = (s_char_code == ctok_pkg::CH_SPACE)
                 || ((s_char_code >= ctok_pkg::CH_TAB) && (s_char_code <= ctok_pkg::CH_CR));
        digit_diff = s_char_code - ctok_pkg::CH_ZERO;
        digit      = digit_diff[3:0];
    end

    // Multiply by ten as two shifts and add the new digit
    assign mac = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {32'd0, digit};

    // Insert a letter at the current word position
    always_comb begin
        buf_ins = buf_reg;
        for (int i = 0; i < 8; i++) begin
            if ((i < MAX_ID_CHARS) && (len_reg == 8'(i))) begin
                buf_ins[8*i +: 8] = s_char_code;
            end
        end
        len_inc = (len_reg == 8'hFF) ? len_reg : len_reg + 8'd1;
    end

    // Build the token for the pending literal or word
    always_comb begin
        flush_tok = '0;
        pend      = 1'b0;
        unique case (mode_reg)
            ctok_pkg::MODE_IDLE: begin
                pend = 1'b0;
            end
            ctok_pkg::MODE_NUM: begin
                pend                     = 1'b1;
                flush_tok.token_kind     = ctok_pkg::KIND_LITERAL;
                flush_tok.int_value      = acc_reg;
                flush_tok.value_overflow = ovf_reg;
            end
            ctok_pkg::MODE_WORD: begin
                pend = 1'b1;
                if ((len_reg == ctok_pkg::KW_INT_LEN) && (buf_reg == ctok_pkg::KW_INT)) begin
                    flush_tok.token_kind = ctok_pkg::KIND_INT;
                end else if ((len_reg == ctok_pkg::KW_RETURN_LEN)
                          && (buf_reg == ctok_pkg::KW_RETURN)) begin
                    flush_tok.token_kind = ctok_pkg::KIND_RETURN;
                end else begin
                    flush_tok.token_kind     = ctok_pkg::KIND_IDENT;
                    flush_tok.ident_text     = buf_reg;
                    flush_tok.ident_length   = len_reg;
                    flush_tok.ident_too_long = (len_reg > 8'(MAX_ID_CHARS));
                end
            end
            default: begin
                pend = 1'b0;
            end
        endcase
    end

    // Decode single-character tokens
    always_comb begin
        char_tok = '0;
        unique case (s_char_code)
            ctok_pkg::CH_LBRACE: char_tok.token_kind = ctok_pkg::KIND_LBRACE;
            ctok_pkg::CH_RBRACE: char_tok.token_kind = ctok_pkg::KIND_RBRACE;
            ctok_pkg::CH_LPAREN: char_tok.token_kind = ctok_pkg::KIND_LPAREN;
            ctok_pkg::CH_RPAREN: char_tok.token_kind = ctok_pkg::KIND_RPAREN;
            ctok_pkg::CH_SEMI:   char_tok.token_kind = ctok_pkg::KIND_SEMI;
            ctok_pkg::CH_MINUS:  char_tok.token_kind = ctok_pkg::KIND_NEG;
            ctok_pkg::CH_TILDE:  char_tok.token_kind = ctok_pkg::KIND_COMPL;
            ctok_pkg::CH_BANG:   char_tok.token_kind = ctok_pkg::KIND_BANG;
            default:             char_tok.token_kind = ctok_pkg::KIND_UNKNOWN;
        endcase
        char_tok.last_of_run = 1'b1;
    end

    // Decide what this request does
    always_comb begin
        take_num   = !s_end_of_input && (mode_reg == ctok_pkg::MODE_NUM) && is_digit;
        take_word  = !s_end_of_input && (mode_reg == ctok_pkg::MODE_WORD) && is_letter;
        emit_flush = pend && !take_num && !take_word;
        emit_char  = !s_end_of_input && !is_digit && !is_letter && !is_space;
    end

    // Queue writes: the flushed token first, then the character token
    always_comb begin
        push    = '0;
        push.v0 = accept && (emit_flush || emit_char);
        push.v1 = accept && emit_flush && emit_char;
        push.t0 = emit_flush ? flush_tok : char_tok;
        push.t0.last_of_run = !(emit_flush && emit_char);
        push.t1 = char_tok;
    end

    // Next scanner state
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        buf_next  = buf_reg;
        len_next  = len_reg;
        if (accept) begin
            if (take_num) begin
                acc_next = mac[31:0];
                ovf_next = ovf_reg | (|mac[35:32]);
            end else if (take_word) begin
                buf_next = buf_ins;
                len_next = len_inc;
            end else begin
                mode_next = ctok_pkg::MODE_IDLE;
                acc_next  = '0;
                ovf_next  = 1'b0;
                buf_next  = '0;
                len_next  = '0;
                if (!s_end_of_input && is_digit) begin
                    mode_next = ctok_pkg::MODE_NUM;
                    acc_next  = {28'd0, digit};
                end else if (!s_end_of_input && is_letter) begin
                    mode_next = ctok_pkg::MODE_WORD;
                    buf_next  = {56'd0, s_char_code};
                    len_next  = 8'd1;
                end
            end
        end
    end

    // Hold scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ctok_pkg::MODE_IDLE;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
            buf_reg  <= '0;
            len_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
            buf_reg  <= buf_next;
            len_reg  <= len_next;
        end
    end

endmodule

FILE: hdl/ctok_token_queue.sv
// Token queue between front and back: two writes and one read per cycle.
module ctok_token_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctok_pkg::push_t    push,
    input  logic               pop,
    output logic               q_valid,
    output ctok_pkg::token_t   q_data,
    output logic               can_take
);

    ctok_pkg::token_t                entries_reg [ctok_pkg::QDEPTH];
    logic [ctok_pkg::QPTR_W-1:0]     wptr_reg, wptr_next;
    logic [ctok_pkg::QPTR_W-1:0]     rptr_reg, rptr_next;
    logic [ctok_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic [ctok_pkg::QPTR_W-1:0]     wptr_plus1;
    logic [ctok_pkg::QCNT_W-1:0]     n_push;

    assign q_valid    = (count_reg != '0);
    assign q_data     = entries_reg[rptr_reg];
    assign can_take   = (count_reg <= ctok_pkg::QCNT_W'(ctok_pkg::QDEPTH - 2));
    assign wptr_plus1 = wptr_reg + ctok_pkg::QPTR_W'(1);

    // Advance pointers and fill count
    always_comb begin
        n_push     = ctok_pkg::QCNT_W'(push.v0) + ctok_pkg::QCNT_W'(push.v1);
        wptr_next  = wptr_reg + n_push[ctok_pkg::QPTR_W-1:0];
        rptr_next  = rptr_reg + ctok_pkg::QPTR_W'(pop);
        count_next = count_reg + n_push - ctok_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store tokens
    always_ff @(posedge aclk) begin
        if (push.v0) begin
            entries_reg[wptr_reg] <= push.t0;
        end
        if (push.v1) begin
            entries_reg[wptr_plus1] <= push.t1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ctok_pkg::QCNT_W'(ctok_pkg::QDEPTH))
        else $error("token queue count out of range");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v0 |-> count_reg <= ctok_pkg::QCNT_W'(ctok_pkg::QDEPTH - 2))
        else $error("token queue written without room");

    a_second_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> push.v0)
        else $error("second token written without first");

    a_last_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.v0 && !push.v1) |-> push.t0.last_of_run)
        else $error("single token not marked last");

    a_last_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> (!push.t0.last_of_run && push.t1.last_of_run))
        else $error("token pair marked wrong");

    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("token queue read while empty");

endmodule

FILE: hdl/ctok_out_stage.sv
// Back end: output register that presents one token at a time to the receiver.
module ctok_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  ctok_pkg::token_t   q_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output ctok_pkg::token_t   out_tok
);

    logic             valid_reg;
    ctok_pkg::token_t tok_reg;

    // Load when empty or the current token leaves
    assign pop     = q_valid && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign out_tok = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Hold token payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            tok_reg <= q_data;
        end
    end

endmodule

FILE: hdl/c_subset_tokenizer.sv
// Top level of the C subset tokenizer: front end, token queue and output stage.
//
// Usage: the s_ channel carries one source byte per request (s_char_code), or an
// end-of-input mark (s_end_of_input = 1) that flushes a pending literal or word.
// The m_ channel carries tokens; one request yields zero, one or two tokens,
// and m_last_of_run marks the final token caused by a request.
// Throughput: one request per cycle while s_ready is high, and one token per
// cycle on the output while m_ready is high; the rate is set by the single
// output register draining the token queue. A request's two tokens leave in turn.
// A token is written into the token queue at the edge that takes its request,
// then loaded into the output register once that register is free, which
// raises m_valid.
// s_ready is high while the four-entry token queue has room for two tokens,
// so a stalled receiver fills the queue and then stops input; nothing is lost.
// Reset (aresetn low, synchronous) empties the queue and output register and
// returns the scanner to idle with no pending literal or word.
// MAX_ID_CHARS (6 to 8) sets how many identifier characters are kept.
module c_subset_tokenizer #(
    parameter int MAX_ID_CHARS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [31:0] m_int_value,
    output logic        m_value_overflow,
    output logic [63:0] m_ident_text,
    output logic [7:0]  m_ident_length,
    output logic        m_ident_too_long,
    output logic        m_last_of_run
);

    ctok_pkg::push_t  push;
    ctok_pkg::token_t q_data;
    ctok_pkg::token_t out_tok;
    logic             q_valid, pop, can_take, accept;

    assign s_ready = can_take;
    assign accept  = s_valid && can_take;

    ctok_front #(
        .MAX_ID_CHARS (MAX_ID_CHARS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .s_char_code    (s_char_code),
        .s_end_of_input (s_end_of_input),
        .push           (push)
    );

    ctok_token_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .can_take (can_take)
    );

    ctok_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .out_tok (out_tok)
    );

    // Split the token onto result ports
    assign m_token_kind     = out_tok.token_kind;
    assign m_int_value      = out_tok.int_value;
    assign m_value_overflow = out_tok.value_overflow;
    assign m_ident_text     = out_tok.ident_text;
    assign m_ident_length   = out_tok.ident_length;
    assign m_ident_too_long = out_tok.ident_too_long;
    assign m_last_of_run    = out_tok.last_of_run;

endmodule

FILE: dv/tb_c_subset_tokenizer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the C subset tokenizer: directed table, then random source text.
module tb_c_subset_tokenizer;
    import ctok_pkg::*;

    localparam int ID_CHARS     = 8;
    localparam int RAND_ITEMS   = 925;
    localparam int QUIET_FROM   = 780;
    localparam int MIX_SPAN     = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int PREDICTED    = -1;
    localparam int DIR_ROWS     = 25;
    localparam int LONG_WORD    = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = '0;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_token_kind;
    logic [31:0] m_int_value;
    logic        m_value_overflow;
    logic [63:0] m_ident_text;
    logic [7:0]  m_ident_length;
    logic        m_ident_too_long;
    logic        m_last_of_run;

    // Scanner state of the predictor
    mode_t       scan_st  = MODE_IDLE;
    logic [31:0] num_acc  = '0;
    logic        num_ovf  = 1'b0;
    logic [63:0] word_buf = '0;
    logic [7:0]  word_len = '0;

    token_t tokens_due [$];
    token_t step_toks [$];
    int     errors    = 0;
    int     sent_cnt  = 0;
    int     seen_cnt  = 0;
    int     gap_pct   = 0;
    int     cycles    = 0;
    bit     hold_done = 1'b0;

    // Directed rows: a typed count of tokens, or PREDICTED
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        int         n_typed;
        kind_t      kind;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CH_LBRACE, 1'b0, 1, KIND_LBRACE},
        '{CH_RBRACE, 1'b0, 1, KIND_RBRACE},
        '{CH_LPAREN, 1'b0, 1, KIND_LPAREN},
        '{CH_RPAREN, 1'b0, 1, KIND_RPAREN},
        '{CH_SEMI,   1'b0, 1, KIND_SEMI},
        '{CH_MINUS,  1'b0, 1, KIND_NEG},
        '{CH_TILDE,  1'b0, 1, KIND_COMPL},
        '{CH_BANG,   1'b0, 1, KIND_BANG},
        '{8'hFF,     1'b0, 1, KIND_UNKNOWN},
        '{8'h00,     1'b0, 1, KIND_UNKNOWN},
        '{8'hFF,     1'b1, 0, KIND_UNKNOWN},
        '{8'h69,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h6E,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h74,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{CH_LPAREN, 1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h72,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h65,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h74,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h75,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h72,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h6E,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h73,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h37,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h7A,     1'b0, PREDICTED, KIND_UNKNOWN},
        '{8'h00,     1'b1, PREDICTED, KIND_UNKNOWN}
    };

    string near_words [8] = '{"int", "return", "integer", "returns",
                              "in", "retur", "Int", "iNT"};
    string edge_nums  [4] = '{"4294967295", "4294967296", "0", "99999999999"};
    logic [7:0] punct [8] = '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
                              CH_SEMI, CH_MINUS, CH_TILDE, CH_BANG};

    c_subset_tokenizer #(
        .MAX_ID_CHARS(ID_CHARS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_of_input  (s_end_of_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_int_value     (m_int_value),
        .m_value_overflow(m_value_overflow),
        .m_ident_text    (m_ident_text),
        .m_ident_length  (m_ident_length),
        .m_ident_too_long(m_ident_too_long),
        .m_last_of_run   (m_last_of_run)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic token_t plain_tok(kind_t k);
        token_t t;
        t = '0;
        t.token_kind = k;
        return t;
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0) begin
            return CH_UP_A + 8'($urandom_range(0, 25));
        end
        return CH_LO_A + 8'($urandom_range(0, 25));
    endfunction

    // Emit the pending literal or word, then return to idle
    task automatic flush_pending();
        token_t t;
        t = '0;
        if (scan_st == MODE_NUM) begin
            t.token_kind     = KIND_LITERAL;
            t.int_value      = num_acc;
            t.value_overflow = num_ovf;
            step_toks = {step_toks, t};
        end else if (scan_st == MODE_WORD) begin
            if (word_len == KW_INT_LEN && word_buf == KW_INT) begin
                t.token_kind = KIND_INT;
            end else if (word_len == KW_RETURN_LEN && word_buf == KW_RETURN) begin
                t.token_kind = KIND_RETURN;
            end else begin
                t.token_kind     = KIND_IDENT;
                t.ident_text     = word_buf;
                t.ident_length   = word_len;
                t.ident_too_long = (word_len > ID_CHARS);
            end
            step_toks = {step_toks, t};
        end
        scan_st  = MODE_IDLE;
        num_acc  = '0;
        num_ovf  = 1'b0;
        word_buf = '0;
        word_len = '0;
    endtask

    task automatic add_digit(logic [7:0] c);
        logic [63:0] v;
        v = {32'd0, num_acc} * 64'd10 + 64'(c - CH_ZERO);
        if (v > 64'hFFFF_FFFF) begin
            num_ovf = 1'b1;
        end
        num_acc = v[31:0];
    endtask

    task automatic add_letter(logic [7:0] c);
        if (word_len < ID_CHARS) begin
            word_buf = word_buf | (64'(c) << (8 * word_len));
        end
        if (word_len < 8'd255) begin
            word_len = word_len + 8'd1;
        end
    endtask

    // Predict the tokens caused by one accepted request into step_toks
    task automatic lex_step(logic [7:0] c, logic e);
        kind_t k;
        token_t t;
        step_toks.delete();
        if (e) begin
            flush_pending();
        end else if (scan_st == MODE_NUM && is_digit(c)) begin
            add_digit(c);
        end else if (scan_st == MODE_WORD && is_letter(c)) begin
            add_letter(c);
        end else begin
            flush_pending();
            if (is_digit(c)) begin
                scan_st = MODE_NUM;
                add_digit(c);
            end else if (is_letter(c)) begin
                scan_st = MODE_WORD;
                add_letter(c);
            end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                case (c)
                    CH_LBRACE: k = KIND_LBRACE;
                    CH_RBRACE: k = KIND_RBRACE;
                    CH_LPAREN: k = KIND_LPAREN;
                    CH_RPAREN: k = KIND_RPAREN;
                    CH_SEMI:   k = KIND_SEMI;
                    CH_MINUS:  k = KIND_NEG;
                    CH_TILDE:  k = KIND_COMPL;
                    CH_BANG:   k = KIND_BANG;
                    default:   k = KIND_UNKNOWN;
                endcase
                t = plain_tok(k);
                step_toks = {step_toks, t};
            end
        end
        if (step_toks.size() > 0) begin
            step_toks[step_toks.size() - 1].last_of_run = 1'b1;
        end
    endtask

    // Offer one request, hold it until taken, then record what it should produce
    task automatic send_req(logic [7:0] c, logic e, int n_typed, kind_t kind);
        token_t t;
        if ($urandom_range(1, 100) <= gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_char_code    <= c;
        s_end_of_input <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_cnt++;
        lex_step(c, e);
        if (n_typed == PREDICTED) begin
            tokens_due = {tokens_due, step_toks};
        end else if (n_typed == 1) begin
            t = plain_tok(kind);
            t.last_of_run = 1'b1;
            tokens_due = {tokens_due, t};
        end
    endtask

    task automatic note_mismatch(string what, token_t want, token_t got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%s: expected kind %0d val %h ovf %b text %h len %0d long %b last %b",
                     what, want.token_kind, want.int_value, want.value_overflow,
                     want.ident_text, want.ident_length, want.ident_too_long,
                     want.last_of_run);
            $display("    got      kind %0d val %h ovf %b text %h len %0d long %b last %b",
                     got.token_kind, got.int_value, got.value_overflow,
                     got.ident_text, got.ident_length, got.ident_too_long,
                     got.last_of_run);
        end
    endtask

    // Compare each accepted token with the oldest one due
    initial begin
        token_t got;
        token_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = {m_token_kind, m_int_value, m_value_overflow, m_ident_text,
                       m_ident_length, m_ident_too_long, m_last_of_run};
                seen_cnt++;
                if (tokens_due.size() == 0) begin
                    note_mismatch("unexpected token", '0, got);
                end else begin
                    want = tokens_due.pop_front();
                    if (got !== want) begin
                        note_mismatch("token mismatch", want, got);
                    end
                end
            end
        end
    end

    // Drive m_ready: random stall bursts and one long hold-off to fill the queue
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && seen_cnt >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if ($urandom_range(1, 100) <= gap_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Stop a hung run
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Reset, directed table, random source text, drain
    initial begin
        logic [7:0] piece [$];
        logic [7:0] ch;
        string      w;
        int         pick;
        int         n;
        int         next_mix;
        bit         long_done;
        next_mix  = MIX_SPAN;
        long_done = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_req(dir_rows[i].ch, dir_rows[i].eoi, dir_rows[i].n_typed,
                     dir_rows[i].kind);
        end

        while (sent_cnt < RAND_ITEMS) begin
            // Vary idling density; none near the end
            if (sent_cnt >= QUIET_FROM) begin
                gap_pct = 0;
            end else if (sent_cnt >= next_mix) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                next_mix += MIX_SPAN;
            end
            piece.delete();
            pick = $urandom_range(0, 99);
            if (!long_done && sent_cnt >= 400) begin
                // Overlong word saturates the length count
                for (int j = 0; j < LONG_WORD; j++) begin
                    ch = rand_letter();
                    piece = {piece, ch};
                end
                long_done = 1'b1;
            end else if (pick < 20) begin
                w = near_words[$urandom_range(0, 7)];
                for (int j = 0; j < w.len(); j++) begin
                    ch = 8'(w[j]);
                    piece = {piece, ch};
                end
            end else if (pick < 40) begin
                n = $urandom_range(1, 12);
                for (int j = 0; j < n; j++) begin
                    ch = rand_letter();
                    piece = {piece, ch};
                end
            end else if (pick < 60) begin
                if ($urandom_range(0, 5) == 0) begin
                    w = edge_nums[$urandom_range(0, 3)];
                    for (int j = 0; j < w.len(); j++) begin
                        ch = 8'(w[j]);
                        piece = {piece, ch};
                    end
                end else begin
                    n = $urandom_range(1, 12);
                    for (int j = 0; j < n; j++) begin
                        ch = CH_ZERO + 8'($urandom_range(0, 9));
                        piece = {piece, ch};
                    end
                end
            end else if (pick < 80) begin
                ch = punct[$urandom_range(0, 7)];
                piece = {piece, ch};
            end else if (pick < 90) begin
                send_req(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                         PREDICTED, KIND_UNKNOWN);
            end else if (pick < 95) begin
                send_req(8'($urandom_range(0, 255)), 1'b1, PREDICTED, KIND_UNKNOWN);
            end else begin
                ch = ($urandom_range(0, 1) == 0) ? CH_SPACE
                     : CH_TAB + 8'($urandom_range(0, 4));
                piece = {piece, ch};
            end
            // Separate with whitespace about half the time
            if (piece.size() > 0 && $urandom_range(0, 1) == 0) begin
                ch = ($urandom_range(0, 2) == 0) ? CH_TAB + 8'($urandom_range(0, 4))
                     : CH_SPACE;
                piece = {piece, ch};
            end
            while (piece.size() > 0) begin
                send_req(piece.pop_front(), 1'b0, PREDICTED, KIND_UNKNOWN);
            end
        end
        s_valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/ctok_pkg.sv
hdl/ctok_front.sv
hdl/ctok_token_queue.sv
hdl/ctok_out_stage.sv
hdl/c_subset_tokenizer.sv
dv/tb_c_subset_tokenizer.sv
